// ===== rtl/gmrc_pkg.sv =====
// ----------------------------------------------------------------------------
// gmrc_pkg
// shared constants and types of the greedy minimizer read clusterer
// ----------------------------------------------------------------------------
package gmrc_pkg;

    localparam int MAX_CLUSTERS = 64;
    localparam int TABLE_DEPTH  = 4096;
    localparam int READ_MAX     = 256;

    localparam int CL_W   = $clog2(MAX_CLUSTERS);
    localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
    localparam int TAB_W  = $clog2(TABLE_DEPTH);
    localparam int PRB_W  = $clog2(TABLE_DEPTH + 1);
    localparam int RB_W   = (READ_MAX > 1) ? $clog2(READ_MAX) : 1;
    localparam int LEN_W  = $clog2(READ_MAX + 1);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_ARGMAX,
        ST_DECIDE,
        ST_MARK_RD,
        ST_MARK_PRB,
        ST_MARK_CHK,
        ST_CLEAR,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic init_step;     // clear one table valid bit
        logic latch_in;      // capture input word
        logic probe_start;   // start probe at home slot of key
        logic probe_next;    // step probe slot
        logic probe_rd;      // issue table read
        logic key_from_buf;  // probe key from read buffer
        logic add_hits;      // add hit bitmap to counters
        logic buf_push;      // store minimizer in buffer
        logic argmax_start;
        logic argmax_step;
        logic decide;
        logic buf_rd;
        logic buf_next;
        logic mark_write;    // write chosen bit into table
        logic mark_full;     // no free slot found
        logic clear_step;
        logic finish;        // end of read bookkeeping
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_done;     // last valid bit being cleared
        logic has;
        logic last;
        logic len_full;
        logic slot_empty;
        logic slot_match;
        logic probe_done;    // probed whole table
        logic argmax_done;
        logic do_mark;
        logic buf_done;
        logic clear_done;
        logic out_busy;
    } t_stat;

endpackage

// ===== rtl/gmrc_if.sv =====
// ----------------------------------------------------------------------------
// gmrc_in_if / gmrc_out_if
// valid/ready channels of the clusterer
// ----------------------------------------------------------------------------
interface gmrc_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] minimizer;
    logic [63:0] read_ident;
    logic        has_minimizer;
    logic        last_of_read;
    modport source (output valid, minimizer, read_ident, has_minimizer, last_of_read,
                    input ready);
    modport sink   (input valid, minimizer, read_ident, has_minimizer, last_of_read,
                    output ready);
endinterface

interface gmrc_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_read_ident;
    logic [5:0]  cluster_index;
    logic        opened_new;
    logic [1:0]  overflow;
    modport source (output valid, out_read_ident, cluster_index, opened_new, overflow,
                    input ready);
    modport sink   (input valid, out_read_ident, cluster_index, opened_new, overflow,
                    output ready);
endinterface

// ===== rtl/gmrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gmrc_ctrl
// sequencer for table init, lookup, argmax, marking pass, counter clear and output
// ----------------------------------------------------------------------------
module gmrc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  gmrc_pkg::t_stat i_stat,
    output gmrc_pkg::t_cmd  o_cmd
);

    gmrc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= gmrc_pkg::ST_INIT;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gmrc_pkg::ST_INIT: begin
                if (i_stat.init_done) n_state = gmrc_pkg::ST_IDLE;
            end
            gmrc_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = gmrc_pkg::ST_PROBE_RD;
            end
            gmrc_pkg::ST_PROBE_RD: begin
                if (i_stat.has && !i_stat.len_full) n_state = gmrc_pkg::ST_PROBE_CHK;
                else if (i_stat.last) n_state = gmrc_pkg::ST_ARGMAX;
                else n_state = gmrc_pkg::ST_IDLE;
            end
            gmrc_pkg::ST_PROBE_CHK: begin
                if (i_stat.slot_empty || i_stat.slot_match || i_stat.probe_done) begin
                    n_state = i_stat.last ? gmrc_pkg::ST_ARGMAX : gmrc_pkg::ST_IDLE;
                end else begin
                    n_state = gmrc_pkg::ST_PROBE_CHK;
                end
            end
            gmrc_pkg::ST_ARGMAX: begin
                if (i_stat.argmax_done) n_state = gmrc_pkg::ST_DECIDE;
            end
            gmrc_pkg::ST_DECIDE: begin
                n_state = i_stat.do_mark ? gmrc_pkg::ST_MARK_RD : gmrc_pkg::ST_CLEAR;
            end
            gmrc_pkg::ST_MARK_RD: begin
                n_state = i_stat.buf_done ? gmrc_pkg::ST_CLEAR : gmrc_pkg::ST_MARK_PRB;
            end
            gmrc_pkg::ST_MARK_PRB: n_state = gmrc_pkg::ST_MARK_CHK;
            gmrc_pkg::ST_MARK_CHK: begin
                if (i_stat.slot_empty || i_stat.slot_match || i_stat.probe_done)
                    n_state = gmrc_pkg::ST_MARK_RD;
            end
            gmrc_pkg::ST_CLEAR: begin
                if (i_stat.clear_done) n_state = gmrc_pkg::ST_OUT;
            end
            gmrc_pkg::ST_OUT: begin
                if (!i_stat.out_busy) n_state = gmrc_pkg::ST_IDLE;
            end
            default: n_state = gmrc_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            gmrc_pkg::ST_INIT: o_cmd.init_step = 1'b1;
            gmrc_pkg::ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.latch_in    = i_in_valid;
            end
            gmrc_pkg::ST_PROBE_RD: begin
                o_cmd.probe_start = 1'b1;
                o_cmd.probe_rd    = 1'b1;
                o_cmd.argmax_start = !(i_stat.has && !i_stat.len_full) && i_stat.last;
            end
            gmrc_pkg::ST_PROBE_CHK: begin
                if (i_stat.slot_empty || i_stat.slot_match || i_stat.probe_done) begin
                    o_cmd.add_hits     = i_stat.slot_match;
                    o_cmd.buf_push     = 1'b1;
                    o_cmd.argmax_start = i_stat.last;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    o_cmd.probe_rd   = 1'b1;
                end
            end
            gmrc_pkg::ST_ARGMAX: o_cmd.argmax_step = 1'b1;
            gmrc_pkg::ST_DECIDE: o_cmd.decide = 1'b1;
            gmrc_pkg::ST_MARK_RD: o_cmd.buf_rd = 1'b1;
            gmrc_pkg::ST_MARK_PRB: begin
                o_cmd.key_from_buf = 1'b1;
                o_cmd.probe_start  = 1'b1;
                o_cmd.probe_rd     = 1'b1;
            end
            gmrc_pkg::ST_MARK_CHK: begin
                if (i_stat.slot_empty || i_stat.slot_match) begin
                    o_cmd.mark_write = 1'b1;
                    o_cmd.buf_next   = 1'b1;
                end else if (i_stat.probe_done) begin
                    o_cmd.mark_full  = 1'b1;
                    o_cmd.buf_next   = 1'b1;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    o_cmd.probe_rd   = 1'b1;
                end
            end
            gmrc_pkg::ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                o_cmd.finish     = i_stat.clear_done;
            end
            gmrc_pkg::ST_OUT: o_cmd.out_load = !i_stat.out_busy;
            default: ;
        endcase
    end

endmodule

// ===== rtl/gmrc_datapath.sv =====
// ----------------------------------------------------------------------------
// gmrc_datapath
// minimizer table, read buffer, hit counters and result register
// ----------------------------------------------------------------------------
module gmrc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [15:0]         i_thresh,
    input  logic [63:0]         i_minimizer,
    input  logic [63:0]         i_read_ident,
    input  logic                i_has_minimizer,
    input  logic                i_last_of_read,
    input  gmrc_pkg::t_cmd      i_cmd,
    output gmrc_pkg::t_stat     o_stat,
    gmrc_out_if.source          out_ch
);

    localparam int CL_W  = gmrc_pkg::CL_W;
    localparam int CNT_W = gmrc_pkg::CNT_W;
    localparam int TAB_W = gmrc_pkg::TAB_W;
    localparam int PRB_W = gmrc_pkg::PRB_W;
    localparam int RB_W  = gmrc_pkg::RB_W;
    localparam int LEN_W = gmrc_pkg::LEN_W;
    localparam int NCL   = gmrc_pkg::MAX_CLUSTERS;
    localparam int TD    = gmrc_pkg::TABLE_DEPTH;

    // table memories; valid bits cleared by a pass over all slots after reset
    logic [63:0] r_keys [TD];
    logic [63:0] r_bmp  [TD];
    logic        r_tvalid [TD];
    logic [63:0] r_rbuf [gmrc_pkg::READ_MAX];

    logic [TAB_W-1:0] r_init_idx;
    logic [63:0]      r_mm, r_ident, r_key, r_rd_key, r_rd_bmp, r_buf_q;
    logic             r_has, r_last, r_rd_valid;
    logic [TAB_W-1:0] r_slot, r_rd_slot;
    logic [PRB_W-1:0] r_probes;
    logic [8:0]       r_hits [NCL];
    logic [LEN_W-1:0] r_len;
    logic [CNT_W-1:0] r_ccount;
    logic [1:0]       r_ovf;
    logic [CL_W-1:0]  r_scan, r_best, r_chosen;
    logic [8:0]       r_best_hits;
    logic             r_opened;
    logic [LEN_W-1:0] r_bidx;
    logic             r_ov, r_out_opened;
    logic [63:0]      r_out_ident;
    logic [CL_W-1:0]  r_out_cl;
    logic [1:0]       r_out_ovf;

    logic [63:0]      n_key;
    logic [TAB_W-1:0] n_slot;
    logic [24:0]      lhs;
    logic [24:0]      rhs;
    logic             join_ok;

    assign n_key  = i_cmd.key_from_buf ? r_buf_q : r_mm;
    assign n_slot = i_cmd.probe_start ? n_key[TAB_W-1:0] : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_mm    <= i_minimizer;
            r_ident <= i_read_ident;
            r_has   <= i_has_minimizer;
            r_last  <= i_last_of_read;
        end
        if (i_cmd.probe_start) begin
            r_key    <= n_key;
            r_probes <= '0;
        end else if (i_cmd.probe_next) begin
            r_probes <= r_probes + 1'b1;
        end
        if (i_cmd.probe_start || i_cmd.probe_next) r_slot <= n_slot;
        if (i_cmd.probe_rd) begin
            r_rd_key   <= r_keys[n_slot];
            r_rd_bmp   <= r_bmp[n_slot];
            r_rd_valid <= r_tvalid[n_slot];
            r_rd_slot  <= n_slot;
        end
        if (i_cmd.mark_write) begin
            r_keys[r_rd_slot] <= r_key;
            r_bmp[r_rd_slot]  <= (r_rd_valid ? r_rd_bmp : 64'd0)
                                 | (64'd1 << r_chosen);
        end
        if (i_cmd.init_step) r_tvalid[r_init_idx] <= 1'b0;
        else if (i_cmd.mark_write) r_tvalid[r_rd_slot] <= 1'b1;
        if (i_cmd.buf_push) r_rbuf[r_len[RB_W-1:0]] <= r_mm;
        if (i_cmd.buf_rd)   r_buf_q <= r_rbuf[r_bidx[RB_W-1:0]];
    end

    // slot counter of the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_init_idx <= '0;
        else if (i_cmd.init_step) r_init_idx <= r_init_idx + 1'b1;
    end

    assign o_stat.init_done  = (r_init_idx == TAB_W'(TD - 1));
    assign o_stat.has        = r_has;
    assign o_stat.last       = r_last;
    assign o_stat.len_full   = (r_len == LEN_W'(gmrc_pkg::READ_MAX));
    assign o_stat.slot_empty = !r_rd_valid;
    assign o_stat.slot_match = r_rd_valid && (r_rd_key == r_key);
    assign o_stat.probe_done = (r_probes == PRB_W'(TD - 1));
    assign o_stat.argmax_done = (r_scan == CL_W'(NCL - 1));
    assign o_stat.do_mark    = join_ok || (r_ccount != CNT_W'(NCL));
    assign o_stat.buf_done   = (r_bidx == r_len);
    assign o_stat.clear_done = 1'b1;
    assign o_stat.out_busy   = r_ov && !out_ch.ready;

    // hits * 65536 > threshold * length, compared at full width
    assign lhs = {r_best_hits, 16'd0};
    assign rhs = 25'(i_thresh * 25'(r_len));
    assign join_ok = (r_ccount != '0) && (lhs > rhs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_ccount <= '0;
            r_ovf    <= '0;
            r_ov     <= 1'b0;
            r_opened <= 1'b0;
            for (int c = 0; c < NCL; c++) r_hits[c] <= '0;
        end else begin
            if (i_cmd.add_hits) begin
                for (int c = 0; c < NCL; c++)
                    if (r_rd_bmp[c] && (CNT_W'(c) < r_ccount)) r_hits[c] <= r_hits[c] + 1'b1;
            end
            if (i_cmd.buf_push) r_len <= r_len + 1'b1;
            if (i_cmd.argmax_start) begin
                r_scan      <= '0;
                r_best      <= '0;
                r_best_hits <= '0;
            end else if (i_cmd.argmax_step) begin
                if (r_hits[r_scan] > r_best_hits) begin
                    r_best_hits <= r_hits[r_scan];
                    r_best      <= r_scan;
                end
                r_scan <= r_scan + 1'b1;
            end
            if (i_cmd.decide) begin
                r_bidx <= '0;
                if (join_ok) begin
                    r_chosen <= r_best;
                    r_opened <= 1'b0;
                end else if (r_ccount != CNT_W'(NCL)) begin
                    r_chosen <= r_ccount[CL_W-1:0];
                    r_ccount <= r_ccount + 1'b1;
                    r_opened <= 1'b1;
                end else begin
                    r_chosen <= '0;
                    r_opened <= 1'b0;
                    r_ovf[1] <= 1'b1;
                end
            end
            if (i_cmd.buf_next) r_bidx <= r_bidx + 1'b1;
            if (i_cmd.mark_full) r_ovf[0] <= 1'b1;
            if (i_cmd.finish) begin
                for (int c = 0; c < NCL; c++) r_hits[c] <= '0;
                r_len <= '0;
            end
            if (i_cmd.out_load) r_ov <= 1'b1;
            else if (out_ch.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_ident  <= r_ident;
            r_out_cl     <= r_chosen;
            r_out_opened <= r_opened;
            r_out_ovf    <= r_ovf;
        end
    end

    assign out_ch.valid          = r_ov;
    assign out_ch.out_read_ident = r_out_ident;
    assign out_ch.cluster_index  = 6'(r_out_cl);
    assign out_ch.opened_new     = r_out_opened;
    assign out_ch.overflow       = r_out_ovf;

endmodule

// ===== rtl/greedy_minimizer_read_clusterer_core.sv =====
// ----------------------------------------------------------------------------
// greedy_minimizer_read_clusterer_core
// greedy clustering of reads by shared minimizers
// ----------------------------------------------------------------------------
// One input word is taken at a time. After reset the 4096 table valid bits are
// cleared one a cycle, and no word is taken until that pass is over. A word
// with a minimizer then takes a probe read and one probe check per slot probed
// (at least one; one table read a cycle); a word without one, or one past the
// 256-minimizer buffer, takes only the probe read. A word that closes a read
// adds a scan of the 64 hit counters, a decision step, a read, probe and check
// per buffered minimizer to mark the chosen cluster and a last read to end that
// pass (both skipped when the read is dropped at the cluster limit), a clear
// step and an output step, which waits while the previous result is still held
// in the output register; the next word is taken after the new one is loaded.
module greedy_minimizer_read_clusterer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    gmrc_in_if.sink     in_ch,
    gmrc_out_if.source  out_ch
);

    logic [15:0]     r_thresh;
    gmrc_pkg::t_cmd  cmd;
    gmrc_pkg::t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_thresh <= '0;
        else if (i_cfg_we) r_thresh <= i_cfg_wdata;
    end

    gmrc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gmrc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_thresh        (r_thresh),
        .i_minimizer     (in_ch.minimizer),
        .i_read_ident    (in_ch.read_ident),
        .i_has_minimizer (in_ch.has_minimizer),
        .i_last_of_read  (in_ch.last_of_read),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .out_ch          (out_ch)
    );

endmodule

// ===== tb/tb_greedy_minimizer_read_clusterer_core.sv =====
// ----------------------------------------------------------------------------
// tb_greedy_minimizer_read_clusterer_core
// The testbench streams reads of minimizers into the clusterer and checks
// each read assignment against a predictor kept in step with the stimulus.
// Threshold settings change between phases. The run covers joins, new
// clusters, empty reads, words without a minimizer and reads longer than the
// buffer. It also reaches the cluster limit and ends with a stretch without idling.
// ----------------------------------------------------------------------------
module tb_greedy_minimizer_read_clusterer_core;

    localparam int IDLE_LIMIT = 60000;

    typedef struct {
        bit [63:0] minimizer;
        bit [63:0] read_ident;
        bit        has_minimizer;
        bit        last_of_read;
    } t_word;

    typedef struct {
        bit [63:0] read_ident;
        bit [5:0]  cluster_index;
        bit        opened_new;
        bit [1:0]  overflow;
    } t_assignment;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    gmrc_in_if  in_ch();
    gmrc_out_if out_ch();

    greedy_minimizer_read_clusterer_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    t_word       pending_words[$];
    t_assignment expected_assignments[$];
    int          errors;
    bit          quiet;
    bit          hold_req;
    bit [63:0]   key_pool[48];

    // predictor state
    bit [63:0]   tab_key[gmrc_pkg::TABLE_DEPTH];
    bit          tab_valid[gmrc_pkg::TABLE_DEPTH];
    bit [63:0]   tab_members[gmrc_pkg::TABLE_DEPTH];
    int unsigned cluster_hits[gmrc_pkg::MAX_CLUSTERS];
    bit [63:0]   read_keys[gmrc_pkg::READ_MAX];
    int unsigned read_len;
    int unsigned clusters_open;
    bit [1:0]    sticky_flags;
    bit [15:0]   threshold;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int find_slot(bit [63:0] key, output int free_slot);
        int slot;
        slot = int'(key[gmrc_pkg::TAB_W-1:0]);
        free_slot = -1;
        for (int n = 0; n < gmrc_pkg::TABLE_DEPTH; n++) begin
            if (!tab_valid[slot]) begin
                free_slot = slot;
                return -1;
            end
            if (tab_key[slot] == key) return slot;
            slot = (slot + 1) % gmrc_pkg::TABLE_DEPTH;
        end
        return -1;
    endfunction

    function automatic void mark_cluster(int unsigned cl);
        bit [63:0] member;
        int        hit;
        int        free_slot;
        member = 64'd1 << cl;
        for (int i = 0; i < read_len; i++) begin
            hit = find_slot(read_keys[i], free_slot);
            if (hit >= 0) tab_members[hit] |= member;
            else if (free_slot >= 0) begin
                tab_key[free_slot]     = read_keys[i];
                tab_valid[free_slot]   = 1'b1;
                tab_members[free_slot] = member;
            end else sticky_flags[0] = 1'b1;
        end
    endfunction

    // advance the predictor by one word; returns 1 when a read closes
    function automatic bit assign_read(t_word w, output t_assignment res);
        int          slot;
        int          free_slot;
        int unsigned best;
        int unsigned best_hits;
        int unsigned chosen;
        bit          opened;
        longint unsigned lhs;
        longint unsigned rhs;
        best = 0;
        best_hits = 0;
        chosen = 0;
        opened = 0;
        if (w.has_minimizer && read_len < gmrc_pkg::READ_MAX) begin
            slot = find_slot(w.minimizer, free_slot);
            if (slot >= 0)
                for (int c = 0; c < clusters_open; c++)
                    if (tab_members[slot][c]) cluster_hits[c]++;
            read_keys[read_len] = w.minimizer;
            read_len++;
        end
        if (!w.last_of_read) return 0;
        for (int c = 0; c < clusters_open; c++)
            if (cluster_hits[c] > best_hits) begin
                best_hits = cluster_hits[c];
                best = c;
            end
        lhs = longint'(best_hits) * 65536;
        rhs = longint'(threshold) * longint'(read_len);
        if (clusters_open > 0 && lhs > rhs) begin
            chosen = best;
            mark_cluster(chosen);
        end else if (clusters_open < gmrc_pkg::MAX_CLUSTERS) begin
            chosen = clusters_open;
            clusters_open++;
            opened = 1;
            mark_cluster(chosen);
        end else sticky_flags[1] = 1'b1;
        foreach (cluster_hits[c]) cluster_hits[c] = 0;
        read_len = 0;
        res.read_ident    = w.read_ident;
        res.cluster_index = chosen[5:0];
        res.opened_new    = opened;
        res.overflow      = sticky_flags;
        return 1;
    endfunction

    task automatic queue_word(bit [63:0] mm, bit has, bit last, bit [63:0] id);
        t_word       w;
        t_assignment res;
        w.minimizer     = mm;
        w.read_ident    = id;
        w.has_minimizer = has;
        w.last_of_read  = last;
        pending_words = {pending_words, w};
        if (assign_read(w, res)) expected_assignments = {expected_assignments, res};
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // fresh_pct: share of minimizers not taken from the pool
    task automatic queue_read(int len, int fresh_pct);
        bit [63:0] mm;
        for (int i = 0; i < len; i++) begin
            mm = ($urandom_range(0, 99) < fresh_pct) ? rand64()
                 : key_pool[$urandom_range(0, 47)];
            queue_word(mm, $urandom_range(0, 99) >= 8, i == len - 1, rand64());
        end
    endtask

    task automatic drain();
        while (pending_words.size() != 0 || in_ch.valid ||
               expected_assignments.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_threshold(bit [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        threshold = value;
    endtask

    task automatic random_phase(int reads, int fresh_pct);
        for (int r = 0; r < reads; r++)
            queue_read($urandom_range(1, 8), fresh_pct);
        drain();
    endtask

    task automatic report_mismatch(string field, bit [63:0] got, bit [63:0] want);
        $display("mismatch on %s: got %h, expected %h", field, got, want);
        errors++;
    endtask

    // stimulus and configuration
    initial begin
        errors        = 0;
        quiet         = 0;
        hold_req      = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        read_len      = 0;
        clusters_open = 0;
        sticky_flags  = '0;
        threshold     = '0;
        foreach (tab_valid[s]) tab_valid[s] = 0;
        foreach (cluster_hits[c]) cluster_hits[c] = 0;
        // a few pool keys share a home slot so that probing walks
        foreach (key_pool[k])
            key_pool[k] = (k < 8) ? ((rand64() & ~64'hfff) | 64'h123) : rand64();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_threshold(16'd0);
        // directed: empty first read, extremes, duplicates, word with no minimizer
        queue_word(64'd0, 1'b0, 1'b1, 64'd0);
        queue_word(64'd0, 1'b1, 1'b0, 64'hffff_ffff_ffff_ffff);
        queue_word(64'hffff_ffff_ffff_ffff, 1'b1, 1'b1, 64'd1);
        queue_word(64'd0, 1'b1, 1'b0, 64'd2);
        queue_word(64'd0, 1'b1, 1'b0, 64'd3);
        queue_word(64'hffff_ffff_ffff_ffff, 1'b0, 1'b0, 64'd4);
        queue_word(64'h0000_0000_0000_1000, 1'b1, 1'b1, 64'd5);
        queue_word(64'd0, 1'b0, 1'b1, 64'hffff_ffff_ffff_ffff);
        queue_word(key_pool[0], 1'b1, 1'b0, 64'd6);
        queue_word(key_pool[1], 1'b1, 1'b1, 64'd7);
        queue_word(key_pool[0], 1'b1, 1'b0, 64'd8);
        queue_word(key_pool[2], 1'b1, 1'b1, 64'd9);
        drain();

        hold_req = 1;
        // a read longer than the buffer
        queue_read($urandom_range(280, 300), 5);
        random_phase(35, 10);
        write_threshold(16'd32768);
        random_phase(35, 15);
        write_threshold(16'($urandom_range(1, 65534)));
        random_phase(30, 10);
        // threshold at the top: fresh keys open clusters up to the limit
        write_threshold(16'hffff);
        while (clusters_open < gmrc_pkg::MAX_CLUSTERS) queue_read($urandom_range(1, 3), 100);
        random_phase(10, 20);
        write_threshold(16'd1);
        queue_read($urandom_range(280, 300), 5);
        random_phase(20, 10);
        write_threshold(16'd0);

        // last stretch with no idling on either side
        quiet = 1;
        random_phase(15, 10);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_assignments.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // word driver
    int gap_left;
    initial begin
        in_ch.valid         = 1'b0;
        in_ch.minimizer     = '0;
        in_ch.read_ident    = '0;
        in_ch.has_minimizer = 1'b0;
        in_ch.last_of_read  = 1'b0;
        gap_left            = 0;
    end

    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                w = pending_words.pop_front();
                in_ch.valid         <= 1'b1;
                in_ch.minimizer     <= w.minimizer;
                in_ch.read_ident    <= w.read_ident;
                in_ch.has_minimizer <= w.has_minimizer;
                in_ch.last_of_read  <= w.last_of_read;
                if (!quiet && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 16);
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink with bursty stalls and one long hold-off
    int  stall_left;
    int  calm_cnt;
    bit  calm;
    bit  hold_done;
    initial begin
        out_ch.ready = 1'b0;
        stall_left   = 0;
        calm_cnt     = 0;
        calm         = 0;
        hold_done    = 0;
    end

    always @(posedge i_clk) begin
        calm_cnt++;
        if (calm_cnt % 256 == 0) calm = ($urandom_range(0, 3) == 0);
        if (hold_req && !hold_done) begin
            hold_done = 1;
            stall_left = 400;
        end
        if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (!quiet && !calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 15);
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_assignment want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_assignments.size() == 0) begin
                report_mismatch("unexpected word", out_ch.out_read_ident, 64'd0);
            end else begin
                want = expected_assignments.pop_front();
                if (out_ch.out_read_ident !== want.read_ident)
                    report_mismatch("read_ident", out_ch.out_read_ident, want.read_ident);
                if (out_ch.cluster_index !== want.cluster_index)
                    report_mismatch("cluster_index", out_ch.cluster_index, want.cluster_index);
                if (out_ch.opened_new !== want.opened_new)
                    report_mismatch("opened_new", out_ch.opened_new, want.opened_new);
                if (out_ch.overflow !== want.overflow)
                    report_mismatch("overflow", out_ch.overflow, want.overflow);
            end
        end
    end

    // watchdog on cycles without any handshake
    int idle_cycles;
    initial idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

// ===== filelist.f =====
rtl/gmrc_pkg.sv
rtl/gmrc_if.sv
rtl/gmrc_ctrl.sv
rtl/gmrc_datapath.sv
rtl/greedy_minimizer_read_clusterer_core.sv
tb/tb_greedy_minimizer_read_clusterer_core.sv
